### rtl/cqb_pkg.sv
// ----------------------------------------------------------------------------
// cqb_pkg
// shared types and constants of the circular queue buffer
// ----------------------------------------------------------------------------
package cqb_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int CAP_W     = 7;
  localparam int VAL_W     = 32;
  localparam int CAP_RESET = 64;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_DELETE  = 2'd1,
    OP_DISPLAY = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_OUT
  } state_e;

endpackage

### rtl/cqb_if.sv
// ----------------------------------------------------------------------------
// cqb_in_if / cqb_out_if
// valid/ready channels of the circular queue buffer
// ----------------------------------------------------------------------------
interface cqb_in_if
  import cqb_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [1:0]              operation;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface cqb_out_if
  import cqb_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic signed [VAL_W-1:0] value_res;
  logic                    last;

  modport source (output valid, output status, output value_res, output last, input ready);
  modport sink   (input valid, input status, input value_res, input last, output ready);
endinterface

### rtl/cqb_store.sv
// ----------------------------------------------------------------------------
// cqb_store
// slot memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module cqb_store
  import cqb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  logic signed [VAL_W-1:0]    wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic signed [VAL_W-1:0]    rdata_o
);

  logic signed [VAL_W-1:0] mem_q [DEPTH];
  logic signed [VAL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/cqb_step.sv
// ----------------------------------------------------------------------------
// cqb_step
// shared slot advance: increment with wrap at the capacity in use
// ----------------------------------------------------------------------------
module cqb_step
  import cqb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic [$clog2(DEPTH)-1:0] idx_i,
  input  logic [$clog2(DEPTH)-1:0] cap_m1_i,
  output logic [$clog2(DEPTH)-1:0] nxt_o
);

  localparam int IW = $clog2(DEPTH);

  assign nxt_o = (idx_i >= cap_m1_i) ? '0 : idx_i + IW'(1);

endmodule

### rtl/circular_queue_buffer.sv
// insert: result shown in S_OUT, after S_EXEC following the input transaction
// delete: S_EXEC, S_READ (registered memory read, skipped if empty), result in S_OUT
// display: each element via S_EXEC, S_READ, S_OUT; next element after out ready
// one transaction in flight; next input taken the cycle after the last result
// reset: queue empty, capacity min(64, DEPTH); slot memory is not cleared
// ----------------------------------------------------------------------------
// circular_queue_buffer
// circular fifo of signed words with a configurable capacity, sequenced
// around one slot memory and one shared wrap incrementer
// ----------------------------------------------------------------------------
module circular_queue_buffer
  import cqb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_data_i,
  cqb_in_if.sink           in_i,
  cqb_out_if.source        out_o
);

  localparam int IW     = $clog2(DEPTH);
  localparam int CMPW   = (IW + 1 > CAP_W) ? IW + 1 : CAP_W;
  localparam int CapRst = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

  state_e                  state_q, state_d;
  op_e                     op_q, op_d;
  logic signed [VAL_W-1:0] val_q, val_d;
  logic [IW-1:0]           head_q, head_d;
  logic [IW-1:0]           tail_q, tail_d;
  logic [IW-1:0]           ptr_q, ptr_d;
  logic                    empty_q, empty_d;
  logic [IW-1:0]           cap_m1_q, cap_m1_d;
  status_e                 status_q, status_d;
  logic signed [VAL_W-1:0] res_q, res_d;
  logic                    last_q, last_d;

  logic [IW-1:0]           step_in;
  logic [IW-1:0]           step_nxt;
  logic                    mem_we;
  logic [IW-1:0]           mem_waddr;
  logic                    mem_re;
  logic signed [VAL_W-1:0] mem_rdata;
  logic [CMPW-1:0]         cfg_ext;

  cqb_step #(.DEPTH(DEPTH)) u_step (
    .idx_i    (step_in),
    .cap_m1_i (cap_m1_q),
    .nxt_o    (step_nxt)
  );

  cqb_store #(.DEPTH(DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (val_q),
    .re_i    (mem_re),
    .raddr_i (ptr_q),
    .rdata_o (mem_rdata)
  );

  assign step_in = (state_q == S_EXEC) ? tail_q : ptr_q;
  assign cfg_ext = CMPW'(cfg_data_i);

  assign in_i.ready      = (state_q == S_IDLE);
  assign out_o.valid     = (state_q == S_OUT);
  assign out_o.status    = status_q;
  assign out_o.value_res = res_q;
  assign out_o.last      = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      tail_q   <= '0;
      empty_q  <= 1'b1;
      cap_m1_q <= IW'(CapRst - 1);
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      empty_q  <= empty_d;
      cap_m1_q <= cap_m1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    val_q    <= val_d;
    ptr_q    <= ptr_d;
    status_q <= status_d;
    res_q    <= res_d;
    last_q   <= last_d;
  end

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    val_d     = val_q;
    head_d    = head_q;
    tail_d    = tail_q;
    ptr_d     = ptr_q;
    empty_d   = empty_q;
    cap_m1_d  = cap_m1_q;
    status_d  = status_q;
    res_d     = res_q;
    last_d    = last_q;
    mem_we    = 1'b0;
    mem_waddr = tail_q;
    mem_re    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d    = op_e'(in_i.operation);
          val_d   = in_i.value;
          ptr_d   = head_q;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        status_d = ST_OK;
        res_d    = '0;
        last_d   = 1'b1;
        state_d  = S_OUT;
        case (op_q)
          OP_INSERT: begin
            if (empty_q) begin
              head_d    = '0;
              tail_d    = '0;
              empty_d   = 1'b0;
              mem_we    = 1'b1;
              mem_waddr = '0;
            end else if (step_nxt == head_q) begin
              status_d = ST_OVERFLOW;
            end else begin
              tail_d    = step_nxt;
              mem_we    = 1'b1;
              mem_waddr = step_nxt;
            end
          end
          OP_DELETE, OP_DISPLAY: begin
            if (empty_q) begin
              status_d = ST_EMPTY;
            end else begin
              mem_re  = 1'b1;
              state_d = S_READ;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_READ: begin
        status_d = ST_OK;
        res_d    = mem_rdata;
        state_d  = S_OUT;
        if (op_q == OP_DELETE) begin
          last_d = 1'b1;
          if (head_q == tail_q) begin
            head_d  = '0;
            tail_d  = '0;
            empty_d = 1'b1;
          end else begin
            head_d = step_nxt;
          end
        end else begin
          last_d = (ptr_q == tail_q);
          ptr_d  = step_nxt;
        end
      end
      S_OUT: begin
        if (out_o.ready) begin
          state_d = (op_q == OP_DISPLAY && !last_q) ? S_EXEC : S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // capacity write empties the queue
    if (cfg_we_i) begin
      head_d  = '0;
      tail_d  = '0;
      empty_d = 1'b1;
      if (cfg_ext == '0) begin
        cap_m1_d = '0;
      end else if (cfg_ext > CMPW'(DEPTH)) begin
        cap_m1_d = IW'(DEPTH - 1);
      end else begin
        cap_m1_d = IW'(cfg_ext - CMPW'(1));
      end
    end
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken while a transaction is in flight");

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && status_q != ST_OK) |-> (last_q && res_q == '0))
    else $error("error result not marked last or not zero");

  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_q |-> (head_q <= cap_m1_q && tail_q <= cap_m1_q))
    else $error("queue index beyond capacity in use");

  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (empty_q && head_q == '0 && tail_q == '0))
    else $error("capacity write did not empty the queue");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(empty_q) |-> (head_q == '0 && tail_q == '0))
    else $error("queue emptied with nonzero indices");

endmodule

### verif/circular_queue_buffer_tb.sv
// ----------------------------------------------------------------------------
// circular_queue_buffer_tb
// self-checking bench for the circular queue buffer: a behavioral queue model
// predicts every result of insert, delete and display transactions, under
// several capacities and random idling on both channels
// ----------------------------------------------------------------------------
module circular_queue_buffer_tb;
  import cqb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH      = DEPTH_DEF;
  localparam int SETTLE      = 10;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    status_e                 status;
    logic signed [VAL_W-1:0] word;
    logic                    last;
  } queue_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CAP_W-1:0] cfg_data_i;

  cqb_in_if  in_if ();
  cqb_out_if out_if ();

  circular_queue_buffer uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // queue model
  logic [VAL_W-1:0] m_slots [QDEPTH];
  int unsigned      m_head;
  int unsigned      m_tail;
  bit               m_empty;
  logic [CAP_W-1:0] m_cap;

  queue_result_t results_due [$];
  int            fail_cnt;
  int            cycles;
  bit            idle_en;
  int            rx_hold;
  int            rx_stall;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int unsigned used_capacity();
    if (m_cap == 0) return 1;
    if (m_cap > QDEPTH) return QDEPTH;
    return m_cap;
  endfunction

  function automatic int unsigned wrap_next(int unsigned idx);
    if (idx >= used_capacity() - 1) return 0;
    return idx + 1;
  endfunction

  function automatic void push_result(status_e st, logic [VAL_W-1:0] w, logic lst);
    queue_result_t r;
    r.status = st;
    r.word   = w;
    r.last   = lst;
    results_due.push_back(r);
  endfunction

  function automatic void mirror_queue_op(op_e op, logic [VAL_W-1:0] val);
    int unsigned idx;
    int          n;
    bit          fin;
    case (op)
      OP_INSERT: begin
        if (m_empty) begin
          m_head     = 0;
          m_tail     = 0;
          m_slots[0] = val;
          m_empty    = 1'b0;
          push_result(ST_OK, '0, 1'b1);
        end else if (wrap_next(m_tail) == m_head) begin
          push_result(ST_OVERFLOW, '0, 1'b1);
        end else begin
          m_tail          = wrap_next(m_tail);
          m_slots[m_tail] = val;
          push_result(ST_OK, '0, 1'b1);
        end
      end
      OP_DELETE: begin
        if (m_empty) begin
          push_result(ST_EMPTY, '0, 1'b1);
        end else begin
          push_result(ST_OK, m_slots[m_head], 1'b1);
          if (m_head == m_tail) begin
            m_head  = 0;
            m_tail  = 0;
            m_empty = 1'b1;
          end else begin
            m_head = wrap_next(m_head);
          end
        end
      end
      OP_DISPLAY: begin
        if (m_empty) begin
          push_result(ST_EMPTY, '0, 1'b1);
        end else begin
          idx = m_head;
          n   = 0;
          do begin
            fin = (idx == m_tail) || (n + 1 >= QDEPTH);
            push_result(ST_OK, m_slots[idx], fin);
            n++;
            idx = wrap_next(idx);
          end while (!fin);
        end
      end
      default: begin
      end
    endcase
  endfunction

  // model update and result checking
  always @(posedge clk_i) begin
    queue_result_t exp_r;
    if (rst_ni) begin
      if (cfg_we_i) begin
        m_cap   = cfg_data_i;
        m_head  = 0;
        m_tail  = 0;
        m_empty = 1'b1;
      end
      if (in_if.valid && in_if.ready) begin
        mirror_queue_op(op_e'(in_if.operation), in_if.value);
      end
      if (out_if.valid && out_if.ready) begin
        if (results_due.size() == 0) begin
          $error("result with none expected: status %0d value_res %0d last %0d",
                 out_if.status, out_if.value_res, out_if.last);
          fail_cnt++;
        end else begin
          exp_r = results_due.pop_front();
          if (out_if.status !== exp_r.status) begin
            $error("status: expected %0d, actual %0d", exp_r.status, out_if.status);
            fail_cnt++;
          end
          if (out_if.value_res !== exp_r.word) begin
            $error("value_res: expected %0d, actual %0d", exp_r.word, out_if.value_res);
            fail_cnt++;
          end
          if (out_if.last !== exp_r.last) begin
            $error("last: expected %0d, actual %0d", exp_r.last, out_if.last);
            fail_cnt++;
          end
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (!idle_en) return 0;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // result receiver
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      out_if.ready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else if (rx_stall > 0) begin
      out_if.ready <= 1'b0;
      rx_stall = rx_stall - 1;
    end else begin
      rx_stall = pick_gap();
      if (rx_stall == 0) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b0;
        rx_stall = rx_stall - 1;
      end
    end
  end

  function automatic logic [VAL_W-1:0] rand_word();
    case ($urandom_range(19))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // called and returns at a falling edge
  task automatic send_item(op_e op, logic [VAL_W-1:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.value     <= val;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  task automatic drain_queue();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (results_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    drain_queue();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= cap;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic test_empty_queue();
    send_item(OP_DELETE, rand_word());
    send_item(OP_DISPLAY, rand_word());
    send_item(OP_NONE, rand_word());
    send_item(OP_INSERT, 32'h8000_0000);
    send_item(OP_INSERT, 32'h7FFF_FFFF);
    send_item(OP_INSERT, 32'h0000_0000);
    send_item(OP_INSERT, 32'hFFFF_FFFF);
    send_item(OP_DISPLAY, rand_word());
    send_item(OP_DELETE, rand_word());
    send_item(OP_DELETE, rand_word());
  endtask

  task automatic test_small_capacity();
    // zero capacity behaves as one slot
    write_capacity(7'd0);
    send_item(OP_INSERT, rand_word());
    send_item(OP_INSERT, rand_word());
    send_item(OP_DISPLAY, rand_word());
    send_item(OP_DELETE, rand_word());
    send_item(OP_DELETE, rand_word());
    write_capacity(7'd2);
    send_item(OP_INSERT, rand_word());
    send_item(OP_INSERT, rand_word());
    send_item(OP_INSERT, rand_word());
    send_item(OP_DELETE, rand_word());
    send_item(OP_INSERT, rand_word());
    send_item(OP_DISPLAY, rand_word());
    send_item(OP_DELETE, rand_word());
    send_item(OP_DELETE, rand_word());
  endtask

  task automatic test_full_under_backpressure();
    // capacity above depth saturates
    write_capacity(7'd127);
    @(posedge clk_i);
    rx_hold = 400;
    @(negedge clk_i);
    idle_en = 1'b0;
    repeat (QDEPTH + 6) send_item(OP_INSERT, rand_word());
    send_item(OP_DISPLAY, rand_word());
    idle_en = 1'b1;
    drain_queue();
    send_item(OP_DELETE, rand_word());
    send_item(OP_INSERT, rand_word());
    send_item(OP_DISPLAY, rand_word());
  endtask

  task automatic random_phase(int n, int insert_pct);
    int r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < insert_pct) send_item(OP_INSERT, rand_word());
      else if (r < 90)    send_item(OP_DELETE, rand_word());
      else if (r < 97)    send_item(OP_DISPLAY, rand_word());
      else                send_item(OP_NONE, rand_word());
    end
  endtask

  task automatic test_random_traffic();
    logic [CAP_W-1:0] caps [8];
    caps = '{7'd3, 7'd64, 7'd1, 7'($urandom_range(63, 6)), 7'd5,
             7'($urandom_range(126, 65)), 7'd2, 7'd127};
    foreach (caps[i]) begin
      write_capacity(caps[i]);
      idle_en = (i != 3);
      random_phase(40, (i % 2 == 0) ? 60 : 40);
    end
    idle_en = 1'b1;
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_data_i      = '0;
    in_if.valid     = 1'b0;
    in_if.operation = OP_NONE;
    in_if.value     = '0;
    out_if.ready    = 1'b0;
    fail_cnt        = 0;
    cycles          = 0;
    idle_en         = 1'b1;
    rx_hold         = 0;
    rx_stall        = 0;
    m_cap           = 7'(CAP_RESET);
    m_head          = 0;
    m_tail          = 0;
    m_empty         = 1'b1;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_queue();
    test_small_capacity();
    test_full_under_backpressure();
    test_random_traffic();

    drain_queue();
    if (fail_cnt == 0 && results_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
